### hdl/ft12_frame_receiver_assert.svh
// Assertion macros for the FT1.2 frame receiver; they expect clk and rst in scope.
`ifndef FT12_FRAME_RECEIVER_ASSERT_SVH
`define FT12_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS

`define FT12_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define FT12_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define FT12_ASSERT_NOW(lbl, ante, cons, msg)

`define FT12_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/ft12_pkg.sv
// Shared types and constants of the FT1.2 frame receiver.
package ft12_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_RESET   = 2'd3;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_HEADER  = 3'd1;
  localparam logic [2:0] ERR_LENGTH  = 3'd2;
  localparam logic [2:0] ERR_CONTROL = 3'd3;
  localparam logic [2:0] ERR_END     = 3'd4;
  localparam logic [2:0] ERR_SUM     = 3'd5;

  // fixed reset-indication header
  localparam logic [7:0] RST_HDR_0 = 8'h10;
  localparam logic [7:0] RST_HDR_1 = 8'hC0;
  localparam logic [7:0] RST_HDR_3 = 8'h16;

  localparam logic [2:0] REG_START_BYTE   = 3'd0;
  localparam logic [2:0] REG_END_BYTE     = 3'd1;
  localparam logic [2:0] REG_ODD_CONTROL  = 3'd2;
  localparam logic [2:0] REG_EVEN_CONTROL = 3'd3;

  localparam logic [7:0] START_BYTE_RESET   = 8'd104;
  localparam logic [7:0] END_BYTE_RESET     = 8'd22;
  localparam logic [7:0] ODD_CONTROL_RESET  = 8'd243;
  localparam logic [7:0] EVEN_CONTROL_RESET = 8'd211;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] odd_control;
    logic [7:0] even_control;
  } cfg_t;

  // one frame outcome handed from the front to the back
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] err;
    logic [5:0] plen;
  } cmd_t;

endpackage

### hdl/ft12_ram.sv
// Generic single-port-write, registered-read RAM.
module ft12_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 29
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/ft12_front.sv
// Front end: header and body parsing, payload capture, frame checks.
module ft12_front import ft12_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 32,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          push,
  output cmd_t          push_cmd,
  input  logic          q_full,
  input  logic          back_busy,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data
);

  localparam logic [7:0] LEN_MAX = 8'(MAX_FRAME_BYTES - 2);

  logic       in_body;
  logic [5:0] byte_index;
  logic [7:0] header_store [3];
  logic [5:0] frame_length;
  logic [7:0] expected_control;
  logic       control_ok;
  logic [7:0] running_sum;
  logic [7:0] received_checksum;

  logic       hdr_done;
  logic       body_done;
  logic       is_payload;
  logic       take;
  logic       hdr_reset;
  logic       hdr_form;
  logic       len_bad;
  logic [5:0] idx_m1;
  logic [2:0] body_err;

  assign hdr_done   = !in_body && (byte_index >= 6'd3);
  assign body_done  = in_body && ({1'b0, byte_index} >= ({1'b0, frame_length} + 7'd1));
  assign is_payload = in_body && !body_done && (byte_index != 6'd0) &&
                      (byte_index != frame_length);

  // payload store is shared with the back end; hold off while it may still drain
  assign in_ready = !q_full && !(is_payload && back_busy);
  assign take     = in_valid && in_ready;

  assign hdr_reset = (header_store[0] == RST_HDR_0) && (header_store[1] == RST_HDR_1) &&
                     (header_store[2] == RST_HDR_1) && (in_byte == RST_HDR_3);
  assign hdr_form  = (header_store[0] == cfg.start_byte) && (in_byte == cfg.start_byte) &&
                     (header_store[1] == header_store[2]);
  assign len_bad   = (header_store[1] == 8'd0) || (header_store[1] > LEN_MAX);

  always_comb begin
    if (!control_ok) begin
      body_err = ERR_CONTROL;
    end else if (in_byte != cfg.end_byte) begin
      body_err = ERR_END;
    end else if (running_sum != received_checksum) begin
      body_err = ERR_SUM;
    end else begin
      body_err = ERR_NONE;
    end
  end

  always_comb begin
    push_cmd = '0;
    push     = 1'b0;
    if (take && hdr_done) begin
      if (hdr_reset) begin
        push          = 1'b1;
        push_cmd.kind = KIND_RESET;
      end else if (!hdr_form) begin
        push          = 1'b1;
        push_cmd.kind = KIND_REJECT;
        push_cmd.err  = ERR_HEADER;
      end else if (len_bad) begin
        push          = 1'b1;
        push_cmd.kind = KIND_REJECT;
        push_cmd.err  = ERR_LENGTH;
      end
    end else if (take && body_done) begin
      push = 1'b1;
      if (body_err != ERR_NONE) begin
        push_cmd.kind = KIND_REJECT;
        push_cmd.err  = body_err;
      end else begin
        push_cmd.kind = KIND_ACCEPT;
        push_cmd.plen = frame_length - 6'd1;
      end
    end
  end

  assign idx_m1  = byte_index - 6'd1;
  assign wr_en   = take && is_payload;
  assign wr_addr = idx_m1[AW-1:0];
  assign wr_data = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body          <= 1'b0;
      byte_index       <= '0;
      frame_length     <= '0;
      expected_control <= ODD_CONTROL_RESET;
      control_ok       <= 1'b0;
      running_sum      <= '0;
      received_checksum <= '0;
    end else if (take) begin
      if (!in_body) begin
        if (hdr_done) begin
          byte_index <= '0;
          if (hdr_reset) begin
            expected_control <= cfg.odd_control;
          end else if (hdr_form && !len_bad) begin
            in_body      <= 1'b1;
            frame_length <= header_store[1][5:0];
            control_ok   <= 1'b0;
          end
        end else begin
          header_store[byte_index[1:0]] <= in_byte;
          byte_index <= byte_index + 6'd1;
        end
      end else if (body_done) begin
        in_body    <= 1'b0;
        byte_index <= '0;
        if (body_err == ERR_NONE) begin
          expected_control <= (expected_control == cfg.odd_control) ?
                              cfg.even_control : cfg.odd_control;
        end
      end else begin
        if (byte_index == 6'd0) begin
          control_ok  <= (in_byte == expected_control);
          running_sum <= in_byte;
        end else if (byte_index == frame_length) begin
          received_checksum <= in_byte;
        end else begin
          running_sum <= running_sum + in_byte;
        end
        byte_index <= byte_index + 6'd1;
      end
    end
  end

  `include "ft12_frame_receiver_assert.svh"

  `FT12_ASSERT_NOW(a_index_in_body, in_body, (byte_index <= frame_length + 6'd1), "index past end")
  `FT12_ASSERT_NOW(a_no_write_busy, wr_en, !back_busy, "payload write while back end drains")

endmodule

### hdl/ft12_queue.sv
// Two-entry command queue between front and back.
module ft12_queue import ft12_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output cmd_t q_cmd
);

  cmd_t       entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_cmd   = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `include "ft12_frame_receiver_assert.svh"

  `FT12_ASSERT_NOW(a_no_overflow, push, !q_full, "push into full queue")
  `FT12_ASSERT_NOW(a_no_underflow, pop, q_valid, "pop from empty queue")

endmodule

### hdl/ft12_back.sv
// Back end: turns frame outcomes into result words, draining the payload store.
module ft12_back import ft12_pkg::*; #(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          pop,
  output logic          busy,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic [7:0]    out_byte,
  output logic [5:0]    payload_len,
  output logic [2:0]    error_code,
  output logic          send_ack,
  output logic          out_last
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_DATA = 2'd2;
  localparam logic [1:0] B_STAT = 2'd3;

  logic [1:0] state;
  logic [5:0] cnt;
  logic [5:0] plen_r;
  logic       out_free;
  logic       is_long;
  logic [5:0] cnt_inc;
  logic       out_load;

  assign out_free = !out_valid || out_ready;
  assign is_long  = (q_cmd.kind == KIND_ACCEPT) && (q_cmd.plen != 6'd0);
  assign pop      = (state == B_IDLE) && q_valid && (is_long || out_free);
  assign busy     = (state != B_IDLE);
  assign rd_en    = (state == B_READ);
  assign rd_addr  = cnt[AW-1:0];
  assign cnt_inc  = cnt + 6'd1;
  // a new word enters the output register this cycle
  assign out_load = (pop && !is_long) ||
                    (((state == B_DATA) || (state == B_STAT)) && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cnt       <= '0;
      plen_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop) begin
            if (is_long) begin
              plen_r <= q_cmd.plen;
              cnt    <= '0;
              state  <= B_READ;
            end else begin
              out_kind    <= q_cmd.kind;
              out_byte    <= '0;
              payload_len <= q_cmd.plen;
              error_code  <= q_cmd.err;
              send_ack    <= (q_cmd.kind == KIND_ACCEPT);
              out_last    <= 1'b1;
            end
          end
        end
        B_READ: begin
          state <= B_DATA;
        end
        B_DATA: begin
          if (out_free) begin
            out_kind    <= KIND_PAYLOAD;
            out_byte    <= rd_data;
            payload_len <= '0;
            error_code  <= ERR_NONE;
            send_ack    <= 1'b0;
            out_last    <= 1'b0;
            cnt         <= cnt_inc;
            state       <= (cnt_inc == plen_r) ? B_STAT : B_READ;
          end
        end
        B_STAT: begin
          if (out_free) begin
            out_kind    <= KIND_ACCEPT;
            out_byte    <= '0;
            payload_len <= plen_r;
            error_code  <= ERR_NONE;
            send_ack    <= 1'b1;
            out_last    <= 1'b1;
            state       <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `include "ft12_frame_receiver_assert.svh"

  `FT12_ASSERT_NOW(a_drain_nonempty, busy, (plen_r != 6'd0) && (cnt <= plen_r), "bad drain count")
  `FT12_ASSERT_NEXT(a_read_then_data, rd_en, (state == B_DATA), "read not followed by data stage")

endmodule

### hdl/ft12_frame_receiver.sv
// Top level of the FT1.2 frame receiver: config registers, front, queue, back, payload RAM.
// Status: a rejected or reset header, or a body end byte, gives a status word through the queue
// and the output register; an accepted frame's payload words pass the queue, B_READ and B_DATA.
// Throughput: one line byte per cycle while the queue has room; payload bytes of a new frame
// wait while the back end drains (RAM read in B_READ, then B_DATA per byte, then B_STAT) or a command waits.
// Reset: synchronous rst clears parsing state and the queue and reloads config defaults.
module ft12_frame_receiver import ft12_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [13:8] payload_len,
                                      // [16:14] error_code, [17] send_ack, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output logic        m_axis_tlast
);

  localparam int DEPTH = MAX_FRAME_BYTES - 3;
  localparam int AW    = $clog2(DEPTH);

  cfg_t          cfg;
  logic          push;
  cmd_t          push_cmd;
  logic          pop;
  logic          q_valid;
  logic          q_full;
  cmd_t          q_cmd;
  logic          back_busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    out_byte;
  logic [5:0]    payload_len;
  logic [2:0]    error_code;
  logic          send_ack;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte   <= START_BYTE_RESET;
      cfg.end_byte     <= END_BYTE_RESET;
      cfg.odd_control  <= ODD_CONTROL_RESET;
      cfg.even_control <= EVEN_CONTROL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_BYTE:   cfg.start_byte   <= cfg_data;
        REG_END_BYTE:     cfg.end_byte     <= cfg_data;
        REG_ODD_CONTROL:  cfg.odd_control  <= cfg_data;
        REG_EVEN_CONTROL: cfg.even_control <= cfg_data;
        default: ;
      endcase
    end
  end

  ft12_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata),
    .push(push),
    .push_cmd(push_cmd),
    .q_full(q_full),
    .back_busy(back_busy || q_valid),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  ft12_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_cmd(push_cmd),
    .pop(pop),
    .q_valid(q_valid),
    .q_full(q_full),
    .q_cmd(q_cmd)
  );

  ft12_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_payload_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  ft12_back #(
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .pop(pop),
    .busy(back_busy),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_kind(m_axis_tuser),
    .out_byte(out_byte),
    .payload_len(payload_len),
    .error_code(error_code),
    .send_ack(send_ack),
    .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, send_ack, error_code, payload_len, out_byte};

endmodule
